// ===== rtl/core/plist_pkg.sv =====
package plist_pkg;

  // command codes carried in the action field
  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_PRIOR  = 3'd4,
    ACT_NEXT   = 3'd5,
    ACT_CLEAR  = 3'd6
  } action_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_NONEIGH  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // one command transfer
  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [6:0]         position;
  } req_t;

  // one result transfer
  typedef struct packed {
    logic signed [31:0] result_value;
    logic [6:0]         result_position;
    logic [2:0]         status;
    logic [6:0]         count;
    logic               is_empty;
  } rsp_t;

  // microprogram step address
  typedef logic [4:0] step_t;

  localparam step_t S_IDLE      = 5'd0;
  localparam step_t S_DISP      = 5'd1;
  localparam step_t S_INS       = 5'd2;
  localparam step_t S_INS_CHK   = 5'd3;
  localparam step_t S_INS_TEST  = 5'd4;
  localparam step_t S_INS_MOVE  = 5'd5;
  localparam step_t S_INS_PUT   = 5'd6;
  localparam step_t S_DEL       = 5'd7;
  localparam step_t S_DEL_TEST  = 5'd8;
  localparam step_t S_DEL_MOVE  = 5'd9;
  localparam step_t S_DEL_FIN   = 5'd10;
  localparam step_t S_GET       = 5'd11;
  localparam step_t S_GET_RD    = 5'd12;
  localparam step_t S_GET_FIN   = 5'd13;
  localparam step_t S_SCAN      = 5'd14;
  localparam step_t S_SCAN_TEST = 5'd15;
  localparam step_t S_SCAN_CMP  = 5'd16;
  localparam step_t S_SCAN_STEP = 5'd17;
  localparam step_t S_HIT       = 5'd18;
  localparam step_t S_LOC       = 5'd19;
  localparam step_t S_PRI       = 5'd20;
  localparam step_t S_PRI_FIN   = 5'd21;
  localparam step_t S_NXT       = 5'd22;
  localparam step_t S_NXT_FIN   = 5'd23;
  localparam step_t S_CLR       = 5'd24;
  localparam step_t S_BADP      = 5'd25;
  localparam step_t S_FULLS     = 5'd26;
  localparam step_t S_NOTF      = 5'd27;
  localparam step_t S_NONB      = 5'd28;
  localparam step_t S_FIN       = 5'd29;

  // sequencing mode of a control word
  typedef enum logic [2:0] {
    SQ_WAIT,
    SQ_NEXT,
    SQ_JUMP,
    SQ_BRANCH,
    SQ_DISPATCH,
    SQ_SPLIT,
    SQ_FINISH
  } seq_t;

  // branch condition select
  typedef enum logic [2:0] {
    C_NONE,
    C_BAD,
    C_FULL,
    C_UP_END,
    C_DN_END,
    C_SCAN_END,
    C_HIT,
    C_FIRST
  } cond_t;

  // index register operation
  typedef enum logic [2:0] {
    K_HOLD,
    K_CLR,
    K_COUNT,
    K_POS,
    K_INC,
    K_DEC
  } kop_t;

  // read address select
  typedef enum logic [1:0] {
    RA_K,
    RA_KM1,
    RA_KP1
  } rsel_t;

  // write operation, always at the index register
  typedef enum logic [1:0] {
    WR_NONE,
    WR_RDATA,
    WR_VALUE
  } wop_t;

  // element count operation
  typedef enum logic [1:0] {
    CN_HOLD,
    CN_INC,
    CN_DEC,
    CN_CLR
  } cop_t;

  // status update
  typedef enum logic [2:0] {
    SO_HOLD,
    SO_BADPOS,
    SO_NOTFOUND,
    SO_NONEIGH,
    SO_FULL
  } sop_t;

  // one control word of the microprogram
  typedef struct packed {
    seq_t  seq;
    cond_t cond;
    step_t target;
    kop_t  k_op;
    rsel_t rd_sel;
    wop_t  wr_op;
    cop_t  cnt_op;
    sop_t  st_op;
    logic  rv_load;
    logic  rp_load;
  } ctrl_t;

  // datapath flags and command seen by the sequencer
  typedef struct packed {
    logic       bad;
    logic       full;
    logic       up_end;
    logic       dn_end;
    logic       scan_end;
    logic       hit;
    logic       first;
    logic [2:0] action;
  } seq_stat_t;

  localparam ctrl_t CTRL_NOP = '{
    seq: SQ_FINISH, cond: C_NONE, target: S_IDLE, k_op: K_HOLD, rd_sel: RA_K,
    wr_op: WR_NONE, cnt_op: CN_HOLD, st_op: SO_HOLD, rv_load: 1'b0, rp_load: 1'b0
  };

  // microprogram table
  function automatic ctrl_t rom(input step_t s);
    ctrl_t c;
    c = CTRL_NOP;
    case (s)
      S_IDLE: begin
        c.seq = SQ_WAIT;
      end
      S_DISP: begin
        c.seq = SQ_DISPATCH;
      end
      // insert: check position, then capacity, then shift up from the end
      S_INS: begin
        c.seq = SQ_BRANCH; c.cond = C_BAD; c.target = S_BADP;
      end
      S_INS_CHK: begin
        c.seq = SQ_BRANCH; c.cond = C_FULL; c.target = S_FULLS; c.k_op = K_COUNT;
      end
      S_INS_TEST: begin
        c.seq = SQ_BRANCH; c.cond = C_UP_END; c.target = S_INS_PUT; c.rd_sel = RA_KM1;
      end
      S_INS_MOVE: begin
        c.seq = SQ_JUMP; c.target = S_INS_TEST; c.wr_op = WR_RDATA; c.k_op = K_DEC;
      end
      S_INS_PUT: begin
        c.wr_op = WR_VALUE; c.cnt_op = CN_INC;
      end
      // delete: shift down from the removed position
      S_DEL: begin
        c.seq = SQ_BRANCH; c.cond = C_BAD; c.target = S_BADP; c.k_op = K_POS;
      end
      S_DEL_TEST: begin
        c.seq = SQ_BRANCH; c.cond = C_DN_END; c.target = S_DEL_FIN; c.rd_sel = RA_KP1;
      end
      S_DEL_MOVE: begin
        c.seq = SQ_JUMP; c.target = S_DEL_TEST; c.wr_op = WR_RDATA; c.k_op = K_INC;
      end
      S_DEL_FIN: begin
        c.cnt_op = CN_DEC;
      end
      // get: one read at the position
      S_GET: begin
        c.seq = SQ_BRANCH; c.cond = C_BAD; c.target = S_BADP; c.k_op = K_POS;
      end
      S_GET_RD: begin
        c.seq = SQ_NEXT; c.rd_sel = RA_K;
      end
      S_GET_FIN: begin
        c.rv_load = 1'b1;
      end
      // linear search for the first match
      S_SCAN: begin
        c.seq = SQ_NEXT; c.k_op = K_CLR;
      end
      S_SCAN_TEST: begin
        c.seq = SQ_BRANCH; c.cond = C_SCAN_END; c.target = S_NOTF; c.rd_sel = RA_K;
      end
      S_SCAN_CMP: begin
        c.seq = SQ_BRANCH; c.cond = C_HIT; c.target = S_HIT;
      end
      S_SCAN_STEP: begin
        c.seq = SQ_JUMP; c.target = S_SCAN_TEST; c.k_op = K_INC;
      end
      S_HIT: begin
        c.seq = SQ_SPLIT;
      end
      S_LOC: begin
        c.rp_load = 1'b1;
      end
      S_PRI: begin
        c.seq = SQ_BRANCH; c.cond = C_FIRST; c.target = S_NONB; c.rd_sel = RA_KM1;
      end
      S_PRI_FIN: begin
        c.rv_load = 1'b1;
      end
      S_NXT: begin
        c.seq = SQ_BRANCH; c.cond = C_DN_END; c.target = S_NONB; c.rd_sel = RA_KP1;
      end
      S_NXT_FIN: begin
        c.rv_load = 1'b1;
      end
      S_CLR: begin
        c.cnt_op = CN_CLR;
      end
      S_BADP: begin
        c.st_op = SO_BADPOS;
      end
      S_FULLS: begin
        c.st_op = SO_FULL;
      end
      S_NOTF: begin
        c.st_op = SO_NOTFOUND;
      end
      S_NONB: begin
        c.st_op = SO_NONEIGH;
      end
      default: begin
        c = CTRL_NOP;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/plist_ram.sv =====
module plist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/plist_seq.sv =====
module plist_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  plist_pkg::seq_stat_t stat,
  output plist_pkg::ctrl_t    ctrl,
  output logic                busy
);

  plist_pkg::step_t pc;
  plist_pkg::step_t pc_next;
  plist_pkg::step_t pc_inc;
  logic             cond_true;

  // fetch the control word of the current step
  assign ctrl   = plist_pkg::rom(pc);
  assign busy   = (pc != plist_pkg::S_IDLE);
  assign pc_inc = pc + plist_pkg::step_t'(1);

  // select the branch condition
  always_comb begin
    case (ctrl.cond)
      plist_pkg::C_BAD:      cond_true = stat.bad;
      plist_pkg::C_FULL:     cond_true = stat.full;
      plist_pkg::C_UP_END:   cond_true = stat.up_end;
      plist_pkg::C_DN_END:   cond_true = stat.dn_end;
      plist_pkg::C_SCAN_END: cond_true = stat.scan_end;
      plist_pkg::C_HIT:      cond_true = stat.hit;
      plist_pkg::C_FIRST:    cond_true = stat.first;
      default:               cond_true = 1'b0;
    endcase
  end

  // compute the next step
  always_comb begin
    pc_next = pc;
    case (ctrl.seq)
      plist_pkg::SQ_WAIT: begin
        if (accept) begin
          pc_next = plist_pkg::S_DISP;
        end
      end
      plist_pkg::SQ_NEXT:   pc_next = pc_inc;
      plist_pkg::SQ_JUMP:   pc_next = ctrl.target;
      plist_pkg::SQ_BRANCH: pc_next = cond_true ? ctrl.target : pc_inc;
      plist_pkg::SQ_DISPATCH: begin
        case (stat.action)
          plist_pkg::ACT_INSERT: pc_next = plist_pkg::S_INS;
          plist_pkg::ACT_DELETE: pc_next = plist_pkg::S_DEL;
          plist_pkg::ACT_GET:    pc_next = plist_pkg::S_GET;
          plist_pkg::ACT_LOCATE: pc_next = plist_pkg::S_SCAN;
          plist_pkg::ACT_PRIOR:  pc_next = plist_pkg::S_SCAN;
          plist_pkg::ACT_NEXT:   pc_next = plist_pkg::S_SCAN;
          plist_pkg::ACT_CLEAR:  pc_next = plist_pkg::S_CLR;
          default:               pc_next = plist_pkg::S_FIN;
        endcase
      end
      plist_pkg::SQ_SPLIT: begin
        case (stat.action)
          plist_pkg::ACT_LOCATE: pc_next = plist_pkg::S_LOC;
          plist_pkg::ACT_PRIOR:  pc_next = plist_pkg::S_PRI;
          plist_pkg::ACT_NEXT:   pc_next = plist_pkg::S_NXT;
          default:               pc_next = plist_pkg::S_FIN;
        endcase
      end
      plist_pkg::SQ_FINISH: pc_next = plist_pkg::S_IDLE;
      default:              pc_next = plist_pkg::S_IDLE;
    endcase
  end

  // hold the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= plist_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/core/positional_list_engine_top.sv =====
// Channel  | Ports                    | Transfer
// ---------+--------------------------+-------------------------------------------
// command  | start, busy, request     | edge with start high and busy low
// result   | done, result             | one cycle with done high, no back-pressure
//
// Run time grows with the elements that insert and delete shift and that locate, prior
// and next compare (all elements when no match is found); one element is moved or
// compared per pass of the microprogram over the single-write, single-read store.
// Busy falls in the done cycle, so the next command may transfer there.
// Reset empties the list at once; store contents stay undefined, with no clearing pass.
module positional_list_engine_top #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  plist_pkg::req_t   request,
  output logic              done,
  output plist_pkg::rsp_t   result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = ((CW > 7) ? CW : 7) + 1;

  plist_pkg::ctrl_t     ctrl;
  plist_pkg::seq_stat_t stat;
  plist_pkg::status_t   st;

  logic              accept;
  logic [2:0]        act;
  logic [31:0]       val;
  logic [6:0]        pos;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     k;
  logic [CW-1:0]     km1;
  logic [31:0]       rv;
  logic [6:0]        rp;
  logic [XW-1:0]     k_x;
  logic [XW-1:0]     kp1_x;
  logic [XW-1:0]     cnt_x;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     lim_x;
  logic              is_ins;
  logic              we;
  logic [AW-1:0]     raddr;
  logic [31:0]       wdata;
  logic [31:0]       rdata;

  assign accept = start && !busy;

  // widen the index, count and position for compares
  assign k_x    = XW'(k);
  assign kp1_x  = k_x + XW'(1);
  assign km1    = k - CW'(1);
  assign cnt_x  = XW'(cnt);
  assign pos_x  = XW'(pos);
  assign is_ins = (act == plist_pkg::ACT_INSERT);
  assign lim_x  = cnt_x + {{(XW-1){1'b0}}, is_ins};

  // flags for the sequencer
  assign stat.bad      = (pos == 7'd0) || (pos_x > lim_x);
  assign stat.full     = (cnt_x == XW'(CAPACITY));
  assign stat.up_end   = (k_x < pos_x);
  assign stat.dn_end   = (kp1_x >= cnt_x);
  assign stat.scan_end = (k_x >= cnt_x);
  assign stat.hit      = (rdata == val);
  assign stat.first    = (k == '0);
  assign stat.action   = act;

  plist_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .stat   (stat),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // select the read address
  always_comb begin
    case (ctrl.rd_sel)
      plist_pkg::RA_KM1: raddr = km1[AW-1:0];
      plist_pkg::RA_KP1: raddr = kp1_x[AW-1:0];
      default:           raddr = k[AW-1:0];
    endcase
  end

  assign we    = (ctrl.wr_op != plist_pkg::WR_NONE);
  assign wdata = (ctrl.wr_op == plist_pkg::WR_VALUE) ? val : rdata;

  plist_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (k[AW-1:0]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // capture the command on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= request.action;
      val <= request.value;
      pos <= request.position;
    end
  end

  // advance the index register
  always_ff @(posedge clk) begin
    case (ctrl.k_op)
      plist_pkg::K_CLR:   k <= '0;
      plist_pkg::K_COUNT: k <= cnt;
      plist_pkg::K_POS:   k <= CW'(pos_x - XW'(1));
      plist_pkg::K_INC:   k <= kp1_x[CW-1:0];
      plist_pkg::K_DEC:   k <= km1;
      default:            k <= k;
    endcase
  end

  // update the element count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (ctrl.cnt_op)
        plist_pkg::CN_INC: cnt <= cnt + CW'(1);
        plist_pkg::CN_DEC: cnt <= cnt - CW'(1);
        plist_pkg::CN_CLR: cnt <= '0;
        default:           cnt <= cnt;
      endcase
    end
  end

  // clear the result on transfer, load it from the microprogram
  always_ff @(posedge clk) begin
    if (accept) begin
      rv <= '0;
      rp <= '0;
      st <= plist_pkg::ST_OK;
    end else begin
      if (ctrl.rv_load) begin
        rv <= rdata;
      end
      if (ctrl.rp_load) begin
        rp <= kp1_x[6:0];
      end
      case (ctrl.st_op)
        plist_pkg::SO_BADPOS:   st <= plist_pkg::ST_BADPOS;
        plist_pkg::SO_NOTFOUND: st <= plist_pkg::ST_NOTFOUND;
        plist_pkg::SO_NONEIGH:  st <= plist_pkg::ST_NONEIGH;
        plist_pkg::SO_FULL:     st <= plist_pkg::ST_FULL;
        default:                st <= st;
      endcase
    end
  end

  // strobe the result in the cycle after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.seq == plist_pkg::SQ_FINISH);
    end
  end

  assign result.result_value    = rv;
  assign result.result_position = rp;
  assign result.status          = st;
  assign result.count           = 7'(cnt);
  assign result.is_empty        = (cnt == '0);

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_x <= XW'(CAPACITY))
    else $error("element count above capacity");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("command transfer did not start the sequencer");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (st != plist_pkg::ST_OK)) |-> (rv == '0))
    else $error("failed command returned a nonzero value");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> busy)
    else $error("store written while idle");
`endif

endmodule
